>>> src/assert_macros.svh
// Assertion macros shared by the HPX reference pixel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define HPXR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define HPXR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/hpxr_pkg.sv
// Shared constants and stage payload types of the HPX reference pixel pipeline.
package hpxr_pkg;

   localparam int MAX_ORDER   = 29;
   localparam int ORDER_W     = 5;
   localparam int INDEX_W     = 62;
   localparam int HALF_W      = 29;
   localparam int BASE_W      = 4;
   localparam int WIDTH_W     = 13;
   localparam int CX_W        = 33;
   localparam int CY_W        = 31;
   localparam int CRPIX_W     = 45;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 160;
   localparam logic [WIDTH_W-1:0] TILE_WIDTH_RESET = 13'd512;
   localparam logic [INDEX_W-1:0] BASE_CELLS = 62'd12;

   // Stage 1 result: base cell and deinterleaved local hash.
   typedef struct packed {
      logic                err;
      logic [ORDER_W-1:0]  order;
      logic [BASE_W-1:0]   base;
      logic [HALF_W-1:0]   iv;
      logic [HALF_W-1:0]   jv;
   } dec_type;

   // Stage 2 result: tile center on the HPX plane.
   typedef struct packed {
      logic                    err;
      logic signed [CX_W-1:0]  x;
      logic signed [CY_W-1:0]  y;
   } pos_type;

   // Stage 3 result: width times the rotated coordinates.
   typedef struct packed {
      logic                       err;
      logic signed [CX_W-1:0]     x;
      logic signed [CY_W-1:0]     y;
      logic        [CRPIX_W-1:0]  p1;
      logic        [CRPIX_W-1:0]  p2;
   } prod_type;

   // Final result beat.
   typedef struct packed {
      logic                       err;
      logic signed [CX_W-1:0]     x;
      logic signed [CY_W-1:0]     y;
      logic        [CRPIX_W-1:0]  c1;
      logic        [CRPIX_W-1:0]  c2;
   } res_type;

endpackage

>>> src/hpxr_decode.sv
// Stage 1: split off the base cell, flag bad indexes, deinterleave the local hash.
`include "assert_macros.svh"

module hpxr_decode
   import hpxr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [ORDER_W-1:0]   order,
   input  logic [INDEX_W-1:0]   index,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dec_type              out_data
);

   logic                valid_ff;
   dec_type             data_ff;
   dec_type             data_in;
   logic [5:0]          shamt;
   logic [INDEX_W-1:0]  upper;
   logic [INDEX_W-1:0]  local_hash;

   always_comb begin
      shamt      = {order, 1'b0};
      upper      = index >> shamt;
      local_hash = index & ~({INDEX_W{1'b1}} << shamt);
      data_in.err   = (order > ORDER_W'(MAX_ORDER)) || (upper >= BASE_CELLS);
      data_in.order = order;
      data_in.base  = upper[BASE_W-1:0];
      for (int k = 0; k < HALF_W; k++) begin
         data_in.iv[k] = local_hash[2*k];
         data_in.jv[k] = local_hash[2*k+1];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   `HPXR_ASSERT_NOW(a_base_in_range, valid_ff && !data_ff.err, data_ff.base < 4'd12, "decode: accepted base cell out of range")

endmodule

>>> src/hpxr_place.sv
// Stage 2: place the base cell on the HPX plane with the wrap cases.
module hpxr_place
   import hpxr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  dec_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pos_type  out_data
);

   logic                    valid_ff;
   pos_type                 data_ff;
   pos_type                 data_in;
   logic        [CY_W-1:0]  nside;
   logic signed [CY_W-1:0]  li;
   logic signed [CY_W-1:0]  hi;
   logic signed [CY_W-1:0]  hterm;
   logic signed [4:0]       lb0;
   logic signed [4:0]       lb;
   logic        [1:0]       q;
   logic signed [CX_W-1:0]  lterm;

   always_comb begin
      nside = CY_W'(1) << in_data.order;
      li    = $signed({2'b00, in_data.iv}) - $signed({2'b00, in_data.jv});
      hi    = $signed({2'b00, in_data.iv}) + $signed({2'b00, in_data.jv})
              - $signed(nside) + $signed(CY_W'(1));
      q     = in_data.base[3:2];
      lb0   = $signed({2'b00, in_data.base[1:0], 1'b0});
      // Equatorial row folds the rightmost cell, and the one before it on its right half; polar rows shift by one.
      unique case (q)
         2'd1: begin
            hterm = '0;
            if (lb0 == 5'sd6 || (lb0 == 5'sd4 && li > 0)) begin
               lb = lb0 - 5'sd8;
            end else begin
               lb = lb0;
            end
         end
         2'd0: begin
            hterm = $signed(nside);
            lb    = (lb0 + 5'sd1 > 5'sd3) ? lb0 - 5'sd7 : lb0 + 5'sd1;
         end
         default: begin
            hterm = -$signed(nside);
            lb    = (lb0 + 5'sd1 > 5'sd3) ? lb0 - 5'sd7 : lb0 + 5'sd1;
         end
      endcase
      lterm = $signed({{(CX_W-5){lb[4]}}, lb}) <<< in_data.order;
      data_in.err = in_data.err;
      if (in_data.err) begin
         data_in.x = '0;
         data_in.y = '0;
      end else begin
         data_in.x = lterm + $signed({{(CX_W-CY_W){li[CY_W-1]}}, li});
         data_in.y = hterm + hi;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> src/hpxr_scale.sv
// Stages 3 and 4: scale the rotated center by the tile width, add the offset.
`include "assert_macros.svh"

module hpxr_scale
   import hpxr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [WIDTH_W-1:0]  tile_width,
   input  logic                in_valid,
   output logic                in_ready,
   input  pos_type             in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output res_type             out_data
);

   logic                      mul_valid_ff;
   logic                      mul_ready;
   prod_type                  mul_ff;
   prod_type                  mul_in;
   logic                      res_valid_ff;
   logic                      res_ready;
   res_type                   res_ff;
   res_type                   res_in;
   logic signed [CX_W:0]      diff;
   logic signed [CX_W:0]      sum;
   logic signed [CX_W+13:0]   prod1;
   logic signed [CX_W+13:0]   prod2;
   logic        [CRPIX_W-1:0] offset;

   always_comb begin
      diff  = $signed({in_data.x[CX_W-1], in_data.x})
              - $signed({{(CX_W+1-CY_W){in_data.y[CY_W-1]}}, in_data.y});
      sum   = $signed({in_data.x[CX_W-1], in_data.x})
              + $signed({{(CX_W+1-CY_W){in_data.y[CY_W-1]}}, in_data.y});
      prod1 = $signed({1'b0, tile_width}) * diff;
      prod2 = $signed({1'b0, tile_width}) * sum;
      mul_in.err = in_data.err;
      mul_in.x   = in_data.x;
      mul_in.y   = in_data.y;
      mul_in.p1  = prod1[CRPIX_W-1:0];
      mul_in.p2  = prod2[CRPIX_W-1:0];
   end

   always_comb begin
      offset     = {{(CRPIX_W-WIDTH_W){1'b0}}, tile_width} + CRPIX_W'(1);
      res_in.err = mul_ff.err;
      res_in.x   = mul_ff.x;
      res_in.y   = mul_ff.y;
      // Drop the offset on rejected beats so every field reads zero.
      res_in.c1  = mul_ff.err ? '0 : mul_ff.p1 + offset;
      res_in.c2  = mul_ff.err ? '0 : mul_ff.p2 + offset;
   end

   assign res_ready = !res_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || res_ready;
   assign in_ready  = mul_ready;
   assign out_valid = res_valid_ff;
   assign out_data  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (res_ready) begin
            res_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready) begin
         mul_ff <= mul_in;
      end
      if (res_ready) begin
         res_ff <= res_in;
      end
   end

   `HPXR_ASSERT_NEXT(a_mul_moves, mul_valid_ff && res_ready, res_valid_ff, "scale: product beat lost between stages")

endmodule

>>> src/healpix_tile_to_hpx_reference_pixel_top.sv
// Top level of the HEALPix tile to HPX reference pixel pipeline.
// Each request beat carries a HEALPix order and a nested tile index; each response
// beat returns the tile center on the HPX plane in tile steps and twice the FITS
// reference pixels for the programmed tile width. The pipeline has four register
// stages (decode, placement, multiply, offset), and one beat per cycle is sustained
// while the output does not stall; the depth is set by the decode shifter and the
// 14 by 34 bit width multipliers. Ready flows back combinationally through the
// stages, and empty stages fill while the output is stalled. A rejected index
// (base cell of twelve or above, or an order above 29) returns index_error set
// with all other fields zero. Write tile_width only while no beats are in flight.
`include "assert_macros.svh"

module healpix_tile_to_hpx_reference_pixel_top
   import hpxr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [WIDTH_W-1:0]     csr_wdata,     // tile_width
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [4:0] tile_order, [66:5] tile_index, [71:67] zero
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [32:0] center_x, [63:33] center_y, [108:64] crpix1_doubled,
   // [153:109] crpix2_doubled, [159:154] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser      // index_error
);

   logic [WIDTH_W-1:0]  tile_width_ff;
   logic                dec_valid;
   logic                dec_ready;
   dec_type             dec_data;
   logic                pos_valid;
   logic                pos_ready;
   pos_type             pos_data;
   res_type             res_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff <= TILE_WIDTH_RESET;
      end else if (csr_we) begin
         tile_width_ff <= csr_wdata;
      end
   end

   hpxr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .order     (req_tdata[ORDER_W-1:0]),
      .index     (req_tdata[ORDER_W+INDEX_W-1:ORDER_W]),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   hpxr_place u_place (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (pos_valid),
      .out_ready (pos_ready),
      .out_data  (pos_data)
   );

   hpxr_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .tile_width (tile_width_ff),
      .in_valid   (pos_valid),
      .in_ready   (pos_ready),
      .in_data    (pos_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (res_data)
   );

   assign rsp_tdata = {(RSP_DATA_W-2*CRPIX_W-CX_W-CY_W)'(0),
                       res_data.c2, res_data.c1, res_data.y, res_data.x};
   assign rsp_tuser = res_data.err;

   `HPXR_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "top: rejected beat carries nonzero fields")
   `HPXR_ASSERT_NOW(a_ready_chain, rsp_tready, req_tready, "top: pipeline stalls while output drains")

endmodule

>>> test/tb_healpix_tile_to_hpx_reference_pixel_top.sv
// Testbench for the HEALPix tile to HPX reference pixel pipeline, self-checking.
module tb_healpix_tile_to_hpx_reference_pixel_top;
   import hpxr_pkg::*;

   localparam int PIPE_LAT    = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_ROWS      = 24;

   localparam res_type NO_RESULT = res_type'{1'b0, 33'sd0, 31'sd0, 45'd0, 45'd0};
   localparam res_type REJECTED  = res_type'{1'b1, 33'sd0, 31'sd0, 45'd0, 45'd0};

   typedef struct {
      logic [ORDER_W-1:0] ord;
      logic [INDEX_W-1:0] idx;
      bit                 typed;
      res_type            want;
   } tile_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [WIDTH_W-1:0]    csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   res_type            pixel_due [$];
   tile_row_type       tile_rows [N_ROWS];
   logic [WIDTH_W-1:0] cur_width;
   res_type            got_pix;
   res_type            want_pix;
   int                 mismatches;
   int                 cycle_count;
   int                 src_pct;
   int                 sink_pct;
   int                 sink_gap;
   int                 sink_hold;

   healpix_tile_to_hpx_reference_pixel_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Tile center and doubled reference pixels for one tile at the given width.
   function automatic res_type predict_pixel(input logic [ORDER_W-1:0] ord,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic [WIDTH_W-1:0] w);
      res_type         r;
      longint unsigned base_cell, hash;
      longint          ii, jj, ns, li, hi, lb, hb, px, py, wl, p1, p2;
      r = NO_RESULT;
      if (ord > MAX_ORDER) begin
         r.err = 1'b1;
         return r;
      end
      base_cell = 64'(idx) >> (2 * ord);
      if (base_cell >= 12) begin
         r.err = 1'b1;
         return r;
      end
      hash = 64'(idx) & ((64'd1 << (2 * ord)) - 64'd1);
      ii = 0;
      jj = 0;
      // split the interleaved hash: even bits give i, odd bits give j
      for (int b = 0; b < MAX_ORDER; b++) begin
         ii[b] = hash[2*b];
         jj[b] = hash[2*b+1];
      end
      ns = 64'sd1 << ord;
      li = ii - jj;
      hi = ii + jj - (ns - 1);
      hb = 1 - longint'(base_cell >> 2);
      lb = longint'(base_cell & 64'd3) * 2;
      if (hb == 0) begin
         // equatorial row wraps the last cell, and the one before it on its right half
         if (lb == 6 || (lb == 4 && li > 0))
            lb -= 8;
      end else begin
         lb += 1;
         if (lb > 3)
            lb -= 8;
      end
      px = lb * ns + li;
      py = hb * ns + hi;
      wl = longint'(w);
      p1 = wl + 1 + wl * (px - py);
      p2 = wl + 1 + wl * (px + py);
      r.x  = px[CX_W-1:0];
      r.y  = py[CY_W-1:0];
      r.c1 = p1[CRPIX_W-1:0];
      r.c2 = p2[CRPIX_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on %s at cycle %0d: got %0h, want %0h",
               field, cycle_count, got, want);
      mismatches++;
   endtask

   // Offer one beat, with an optional idle burst ahead of it, and log its result.
   task automatic send_tile(input logic [ORDER_W-1:0] ord, input logic [INDEX_W-1:0] idx,
                            input bit typed, input res_type want);
      int gap;
      if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, idx, ord};
      do @(posedge clock); while (!req_tready);
      pixel_due.push_back(typed ? want : predict_pixel(ord, idx, cur_width));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pixel_due.size() != 0) @(posedge clock);
   endtask

   task automatic program_width(input logic [WIDTH_W-1:0] w);
      wait_drained();
      repeat (PIPE_LAT) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_width = w;
   endtask

   task automatic run_random(input int count);
      int                 kind;
      logic [ORDER_W-1:0] ord;
      logic [63:0]        raw, base_cell, hash;
      logic [INDEX_W-1:0] idx;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         ord  = (kind < 5) ? 5'($urandom_range(30, 31)) : 5'($urandom_range(0, MAX_ORDER));
         raw  = {$urandom, $urandom};
         hash = raw & ((64'd1 << (2 * ord)) - 64'd1);
         // mostly valid base cells, some just past the last cell, some raw noise
         base_cell = (kind < 80) ? 64'($urandom_range(0, 11)) : 64'($urandom_range(12, 15));
         if (kind < 5 || kind >= 92)
            idx = raw[INDEX_W-1:0];
         else
            idx = INDEX_W'((base_cell << (2 * ord)) | hash);
         send_tile(ord, idx, 1'b0, NO_RESULT);
      end
   endtask

   // Receiver: long hold-off when asked, otherwise random stall bursts.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            rsp_tready <= 1'b0;
            sink_hold--;
         end else if (sink_gap > 0) begin
            rsp_tready <= 1'b0;
            sink_gap--;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct)
               sink_gap = $urandom_range(1, 13);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pix.err = rsp_tuser;
         got_pix.x   = rsp_tdata[32:0];
         got_pix.y   = rsp_tdata[63:33];
         got_pix.c1  = rsp_tdata[108:64];
         got_pix.c2  = rsp_tdata[153:109];
         if (pixel_due.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[63:0], 64'd0);
         end else begin
            want_pix = pixel_due.pop_front();
            if (got_pix.err !== want_pix.err)
               report_mismatch("index_error", 64'(got_pix.err), 64'(want_pix.err));
            if (got_pix.x !== want_pix.x)
               report_mismatch("center_x", 64'(got_pix.x), 64'(want_pix.x));
            if (got_pix.y !== want_pix.y)
               report_mismatch("center_y", 64'(got_pix.y), 64'(want_pix.y));
            if (got_pix.c1 !== want_pix.c1)
               report_mismatch("crpix1_doubled", 64'(got_pix.c1), 64'(want_pix.c1));
            if (got_pix.c2 !== want_pix.c2)
               report_mismatch("crpix2_doubled", 64'(got_pix.c2), 64'(want_pix.c2));
         end
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      mismatches  = 0;
      cycle_count = 0;
      sink_gap    = 0;
      sink_hold   = 0;
      src_pct     = 25;
      sink_pct    = 25;
      cur_width   = TILE_WIDTH_RESET;
      tile_rows = '{
         '{5'd0,  62'd0,  1'b1, res_type'{1'b0, 33'sd1, 31'sd1, 45'd513, 45'd1537}},
         '{5'd0,  62'd4,  1'b1, res_type'{1'b0, 33'sd0, 31'sd0, 45'd513, 45'd513}},
         '{5'd0,  62'd8,  1'b1, res_type'{1'b0, 33'sd1, -31'sd1, 45'd1537, 45'd513}},
         '{5'd0,  62'd11, 1'b0, NO_RESULT},
         '{5'd0,  62'd12, 1'b1, REJECTED},
         '{5'd0,  {INDEX_W{1'b1}}, 1'b1, REJECTED},
         '{5'd1,  62'd14, 1'b0, NO_RESULT},
         '{5'd1,  62'd24, 1'b0, NO_RESULT},
         '{5'd1,  62'd25, 1'b0, NO_RESULT},
         '{5'd1,  62'd26, 1'b0, NO_RESULT},
         '{5'd1,  62'd27, 1'b0, NO_RESULT},
         '{5'd1,  62'd28, 1'b0, NO_RESULT},
         '{5'd2,  62'd95, 1'b0, NO_RESULT},
         '{5'd3,  62'd677, 1'b0, NO_RESULT},
         '{5'd15, 62'd12884901887, 1'b0, NO_RESULT},
         '{5'd15, 62'd12884901888, 1'b1, REJECTED},
         '{5'd29, 62'h2FFF_FFFF_FFFF_FFFF, 1'b0, NO_RESULT},
         '{5'd29, 62'h3000_0000_0000_0000, 1'b1, REJECTED},
         '{5'd29, 62'd0, 1'b0, NO_RESULT},
         '{5'd29, 62'h1555_5555_5555_5555, 1'b0, NO_RESULT},
         '{5'd29, 62'h0AAA_AAAA_AAAA_AAAA, 1'b0, NO_RESULT},
         '{5'd29, 62'h2D55_5555_5555_5555, 1'b0, NO_RESULT},
         '{5'd30, 62'd0, 1'b1, REJECTED},
         '{5'd31, {INDEX_W{1'b1}}, 1'b1, REJECTED}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (tile_rows[r])
         send_tile(tile_rows[r].ord, tile_rows[r].idx, tile_rows[r].typed, tile_rows[r].want);

      program_width(13'd0);
      run_random(240);

      // hold the output long while beats keep coming, so the pipeline backs up
      program_width(13'h1FFF);
      src_pct   = 0;
      sink_hold = 300;
      run_random(240);
      src_pct   = 25;

      program_width(13'd1);
      run_random(120);
      wait_drained();
      run_random(120);

      program_width(13'd4096);
      src_pct  = 10;
      sink_pct = 40;
      run_random(240);

      program_width(13'h0AAA);
      src_pct  = 40;
      sink_pct = 10;
      run_random(240);

      program_width(13'h1555);
      src_pct  = 0;
      sink_pct = 0;
      run_random(120);
      src_pct  = 25;
      sink_pct = 25;
      run_random(120);

      program_width(13'($urandom_range(2, 8190)));
      run_random(240);

      // closing stretch at full rate on both sides
      program_width(13'($urandom_range(2, 8190)));
      src_pct  = 0;
      sink_pct = 0;
      sink_gap = 0;
      run_random(250);

      wait_drained();
      repeat (PIPE_LAT * 4) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
